@@ design/dsp_pkg.sv @@
package dsp_pkg;

   localparam int MAX_NODES     = 64;
   localparam int NODE_BITS     = $clog2(MAX_NODES);
   localparam int COUNT_BITS    = NODE_BITS + 1;
   localparam int MAT_ADDR_BITS = 2 * NODE_BITS;
   localparam int WEIGHT_BITS   = 8;
   localparam int WEIGHT_IN_BITS = 8;
   localparam int DIST_BITS     = 15;
   localparam int DIST_OUT_BITS = 14;
   localparam int CFG_BITS      = 7;
   localparam int STEP_BITS     = 4;

   localparam logic [DIST_BITS-1:0] DIST_INF = '1;
   localparam logic [DIST_BITS:0]   DIST_MAX = (DIST_BITS+1)'(16383);

   typedef enum logic [0:0] {
      CSR_NODE_COUNT  = 1'b0,
      CSR_SOURCE_NODE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NOP        = 4'd0,
      OP_LOAD       = 4'd1,
      OP_INIT       = 4'd2,
      OP_SCAN_SETUP = 4'd3,
      OP_SCAN_RD    = 4'd4,
      OP_MARK       = 4'd5,
      OP_RELAX_RD   = 4'd6,
      OP_ROUND_END  = 4'd7,
      OP_OUT_SETUP  = 4'd8,
      OP_OUT_RD     = 4'd9,
      OP_K_INC      = 4'd10
   } op_type;

   typedef enum logic [2:0] {
      BR_NEVER          = 3'd0,
      BR_ALWAYS         = 3'd1,
      BR_NOT_LAST_ENTRY = 3'd2,
      BR_BAD_SOURCE     = 3'd3,
      BR_K_NOT_LAST     = 3'd4,
      BR_DIST_INF       = 3'd5,
      BR_ROUND_NOT_LAST = 3'd6,
      BR_NO_FIRE        = 3'd7
   } cond_type;

   typedef enum logic [1:0] {
      STG_NONE  = 2'd0,
      STG_SCAN  = 2'd1,
      STG_RELAX = 2'd2,
      STG_OUT   = 2'd3
   } stage_type;

   typedef struct packed {
      op_type                 op;
      cond_type               cond;
      logic [STEP_BITS-1:0]   target;
   } ctrl_word_type;

   localparam logic [STEP_BITS-1:0] STEP_LOAD       = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_INIT       = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_SCAN_SETUP = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_SCAN_RD    = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_SCAN_DRAIN = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_MARK       = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_RELAX_RD   = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_ROUND_END  = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_OUT_SETUP  = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_OUT_RD     = 4'd9;
   localparam logic [STEP_BITS-1:0] STEP_OUT_WAIT   = 4'd10;
   localparam logic [STEP_BITS-1:0] STEP_OUT_NEXT   = 4'd11;
   localparam logic [STEP_BITS-1:0] STEP_DONE       = 4'd12;

   // control store: branch taken goes to target, else step + 1
   function automatic ctrl_word_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ctrl_word_type cw;
      cw = '{op: OP_NOP, cond: BR_ALWAYS, target: STEP_LOAD};
      case (step)
         STEP_LOAD:       cw = '{op: OP_LOAD,       cond: BR_NOT_LAST_ENTRY, target: STEP_LOAD};
         STEP_INIT:       cw = '{op: OP_INIT,       cond: BR_BAD_SOURCE,     target: STEP_OUT_SETUP};
         STEP_SCAN_SETUP: cw = '{op: OP_SCAN_SETUP, cond: BR_NEVER,          target: STEP_LOAD};
         STEP_SCAN_RD:    cw = '{op: OP_SCAN_RD,    cond: BR_K_NOT_LAST,     target: STEP_SCAN_RD};
         STEP_SCAN_DRAIN: cw = '{op: OP_NOP,        cond: BR_NEVER,          target: STEP_LOAD};
         STEP_MARK:       cw = '{op: OP_MARK,       cond: BR_DIST_INF,       target: STEP_ROUND_END};
         STEP_RELAX_RD:   cw = '{op: OP_RELAX_RD,   cond: BR_K_NOT_LAST,     target: STEP_RELAX_RD};
         STEP_ROUND_END:  cw = '{op: OP_ROUND_END,  cond: BR_ROUND_NOT_LAST, target: STEP_SCAN_SETUP};
         STEP_OUT_SETUP:  cw = '{op: OP_OUT_SETUP,  cond: BR_NEVER,          target: STEP_LOAD};
         STEP_OUT_RD:     cw = '{op: OP_OUT_RD,     cond: BR_NEVER,          target: STEP_LOAD};
         STEP_OUT_WAIT:   cw = '{op: OP_NOP,        cond: BR_NO_FIRE,        target: STEP_OUT_WAIT};
         STEP_OUT_NEXT:   cw = '{op: OP_K_INC,      cond: BR_K_NOT_LAST,     target: STEP_OUT_RD};
         STEP_DONE:       cw = '{op: OP_NOP,        cond: BR_ALWAYS,         target: STEP_LOAD};
         default:         cw = '{op: OP_NOP,        cond: BR_ALWAYS,         target: STEP_LOAD};
      endcase
      return cw;
   endfunction

endpackage

@@ design/dsp_req_if.sv @@
interface dsp_req_if;
   logic                               valid;
   logic                               ready;
   logic [dsp_pkg::NODE_BITS-1:0]      row;
   logic [dsp_pkg::NODE_BITS-1:0]      col;
   logic [dsp_pkg::WEIGHT_IN_BITS-1:0] weight;
   logic                               last_entry;

   modport source (output valid, output row, output col, output weight, output last_entry,
                   input ready);
   modport sink   (input valid, input row, input col, input weight, input last_entry,
                   output ready);
endinterface

@@ design/dsp_rsp_if.sv @@
interface dsp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dsp_pkg::NODE_BITS-1:0]     vertex;
   logic [dsp_pkg::DIST_OUT_BITS-1:0] distance;
   logic                              reachable;
   logic                              last_result;

   modport source (output valid, output vertex, output distance, output reachable,
                   output last_result, input ready);
   modport sink   (input valid, input vertex, input distance, input reachable,
                   input last_result, output ready);
endinterface

@@ design/dense_shortest_path_engine.sv @@
// Single-source shortest paths over a dense weighted adjacency matrix. Matrix entries are
// taken one beat per cycle into a 4096 x 8 on-chip memory (weight 0 means no edge); every
// entry that a search can reach must have been written beforehand. The beat flagged
// last_entry is stored and then starts a search from source_node over node_count vertices
// (n). The search is run by a small control store stepping a single datapath with one
// distance memory read and one write per cycle: each of the n rounds scans all distances
// for the minimum, then relaxes the picked vertex's row, which is skipped when the picked
// vertex is unreachable. Results follow in vertex order, one at a time: the next vertex
// is read only after the sink has taken the previous result. No input beat is taken from
// the last_entry beat until the final result has been handed over. A source at or above n
// skips the search and reports every vertex unreachable with distance 0.
module dense_shortest_path_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  dsp_pkg::csr_index_type          csr_index,
   input  logic [dsp_pkg::CFG_BITS-1:0]    csr_wdata,
   dsp_req_if.sink                         req,
   dsp_rsp_if.source                       rsp
);
   import dsp_pkg::*;

   ctrl_word_type cw;
   logic [STEP_BITS-1:0] pc_ff, pc_in;
   logic                 branch;

   logic [COUNT_BITS-1:0] node_count_ff, node_count_in;
   logic [NODE_BITS-1:0]  source_ff, source_in;

   logic [NODE_BITS-1:0] k_ff, k_in;
   logic [NODE_BITS-1:0] round_ff, round_in;
   logic [NODE_BITS-1:0] n_last_ff, n_last_in;
   logic [NODE_BITS-1:0] chosen_ff, chosen_in;
   logic [DIST_BITS:0]   best_ff, best_in;
   logic                 valid_src_ff, valid_src_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] dist_vld_ff, dist_vld_in;

   stage_type            stg_ff, stg_in;
   logic [NODE_BITS-1:0] stg_idx_ff;

   logic [WEIGHT_BITS-1:0] mat_mem_ff [MAX_NODES*MAX_NODES];
   logic [DIST_BITS-1:0]   dist_mem_ff [MAX_NODES];
   logic [WEIGHT_BITS-1:0] mat_rd_ff;
   logic [DIST_BITS-1:0]   dist_rd_ff;
   logic                   dist_rd_vld_ff;

   logic                 dist_we;
   logic [NODE_BITS-1:0] dist_wa;
   logic [DIST_BITS-1:0] dist_wd;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [NODE_BITS-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic [DIST_OUT_BITS-1:0] rsp_distance_ff, rsp_distance_in;
   logic                     rsp_reachable_ff, rsp_reachable_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                 req_fire, rsp_fire;
   logic [NODE_BITS-1:0] n_last_cfg;
   logic                 bad_src;
   logic [DIST_BITS-1:0] d_eff;
   logic [DIST_BITS:0]   sum;
   logic [DIST_BITS-1:0] sat;
   logic                 reach;

   assign cw       = ucode_rom(pc_ff);
   assign req.ready = (cw.op == OP_LOAD);
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp_valid_ff && rsp.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.vertex      = rsp_vertex_ff;
   assign rsp.distance    = rsp_distance_ff;
   assign rsp.reachable   = rsp_reachable_ff;
   assign rsp.last_result = rsp_last_ff;

   // zero counts as one vertex, oversize counts as the full matrix
   always_comb begin
      if (node_count_ff == '0) begin
         n_last_cfg = '0;
      end else if (node_count_ff > COUNT_BITS'(MAX_NODES)) begin
         n_last_cfg = NODE_BITS'(MAX_NODES - 1);
      end else begin
         n_last_cfg = NODE_BITS'(node_count_ff - COUNT_BITS'(1));
      end
   end

   assign bad_src = (source_ff > n_last_cfg);

   // entries not written in this search read as infinity
   assign d_eff = dist_rd_vld_ff ? dist_rd_ff : DIST_INF;
   assign sum   = {1'b0, best_ff[DIST_BITS-1:0]} + (DIST_BITS+1)'(mat_rd_ff);
   assign sat   = (sum > DIST_MAX) ? DIST_MAX[DIST_BITS-1:0] : sum[DIST_BITS-1:0];
   assign reach = valid_src_ff && (d_eff != DIST_INF);

   always_comb begin
      case (cw.cond)
         BR_NEVER:          branch = 1'b0;
         BR_ALWAYS:         branch = 1'b1;
         BR_NOT_LAST_ENTRY: branch = !(req_fire && req.last_entry);
         BR_BAD_SOURCE:     branch = bad_src;
         BR_K_NOT_LAST:     branch = (k_ff != n_last_ff);
         BR_DIST_INF:       branch = (best_ff == {1'b0, DIST_INF});
         BR_ROUND_NOT_LAST: branch = (round_ff != n_last_ff);
         BR_NO_FIRE:        branch = !rsp_fire;
         default:           branch = 1'b0;
      endcase
   end

   always_comb begin
      pc_in            = branch ? cw.target : pc_ff + STEP_BITS'(1);
      node_count_in    = node_count_ff;
      source_in        = source_ff;
      k_in             = k_ff;
      round_in         = round_ff;
      n_last_in        = n_last_ff;
      chosen_in        = chosen_ff;
      best_in          = best_ff;
      valid_src_in     = valid_src_ff;
      visited_in       = visited_ff;
      dist_vld_in      = dist_vld_ff;
      stg_in           = STG_NONE;
      dist_we          = 1'b0;
      dist_wa          = stg_idx_ff;
      dist_wd          = sat;
      rsp_valid_in     = rsp_valid_ff && !rsp_fire;
      rsp_vertex_in    = rsp_vertex_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_reachable_in = rsp_reachable_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT:  node_count_in = csr_wdata;
            CSR_SOURCE_NODE: source_in = csr_wdata[NODE_BITS-1:0];
            default:         node_count_in = node_count_ff;
         endcase
      end

      case (cw.op)
         OP_INIT: begin
            n_last_in    = n_last_cfg;
            valid_src_in = !bad_src;
            round_in     = '0;
            visited_in   = '0;
            dist_vld_in  = '0;
            if (!bad_src) begin
               dist_vld_in[source_ff] = 1'b1;
               dist_we = 1'b1;
               dist_wa = source_ff;
               dist_wd = '0;
            end
         end
         OP_SCAN_SETUP: begin
            k_in      = '0;
            best_in   = {1'b1, {DIST_BITS{1'b0}}};
            chosen_in = '0;
         end
         OP_SCAN_RD: begin
            stg_in = STG_SCAN;
            k_in   = k_ff + NODE_BITS'(1);
         end
         OP_MARK: begin
            visited_in[chosen_ff] = 1'b1;
            k_in = '0;
         end
         OP_RELAX_RD: begin
            stg_in = STG_RELAX;
            k_in   = k_ff + NODE_BITS'(1);
         end
         OP_ROUND_END: round_in = round_ff + NODE_BITS'(1);
         OP_OUT_SETUP: k_in = '0;
         OP_OUT_RD:    stg_in = STG_OUT;
         OP_K_INC:     k_in = k_ff + NODE_BITS'(1);
         default:      k_in = k_ff;
      endcase

      // second half of the read pipeline: data of the index issued last cycle
      case (stg_ff)
         STG_SCAN: begin
            // <= keeps the highest index on ties
            if (!visited_ff[stg_idx_ff] && ({1'b0, d_eff} <= best_ff)) begin
               best_in   = {1'b0, d_eff};
               chosen_in = stg_idx_ff;
            end
         end
         STG_RELAX: begin
            if (!visited_ff[stg_idx_ff] && (mat_rd_ff != '0) && (sat < d_eff)) begin
               dist_we = 1'b1;
               dist_vld_in[stg_idx_ff] = 1'b1;
            end
         end
         STG_OUT: begin
            rsp_valid_in     = 1'b1;
            rsp_vertex_in    = stg_idx_ff;
            rsp_reachable_in = reach;
            rsp_distance_in  = reach ? d_eff[DIST_OUT_BITS-1:0] : '0;
            rsp_last_in      = (stg_idx_ff == n_last_ff);
         end
         default: rsp_valid_in = rsp_valid_ff && !rsp_fire;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_LOAD;
         node_count_ff <= COUNT_BITS'(MAX_NODES);
         source_ff     <= '0;
         stg_ff        <= STG_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         node_count_ff <= node_count_in;
         source_ff     <= source_in;
         stg_ff        <= stg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff             <= k_in;
      round_ff         <= round_in;
      n_last_ff        <= n_last_in;
      chosen_ff        <= chosen_in;
      best_ff          <= best_in;
      valid_src_ff     <= valid_src_in;
      visited_ff       <= visited_in;
      dist_vld_ff      <= dist_vld_in;
      stg_idx_ff       <= k_ff;
      rsp_vertex_ff    <= rsp_vertex_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_reachable_ff <= rsp_reachable_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mat_mem_ff[{req.row, req.col}] <= req.weight[WEIGHT_BITS-1:0];
      end
      mat_rd_ff <= mat_mem_ff[{chosen_ff, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem_ff[dist_wa] <= dist_wd;
      end
      dist_rd_ff     <= dist_mem_ff[k_ff];
      dist_rd_vld_ff <= dist_vld_ff[k_ff];
   end

   a_no_load_while_reporting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready)
      else $error("input taken while a result is pending");

   a_pick_unvisited: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_MARK) |-> !visited_ff[chosen_ff])
      else $error("search picked a visited vertex");

   a_last_result_vertex: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_vertex_ff == n_last_ff))
      else $error("last result flag on wrong vertex");

   a_start_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.last_entry) |=> (pc_ff == STEP_INIT))
      else $error("search did not start after last entry");

endmodule
